### sv/tps_pkg.sv
// Shared constants for the trapezoid pulse source: default widths,
// register indexes of the configuration port and section codes.
// No dependencies.
package tps_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int LEVEL_WIDTH_DEF = 24;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_LEVEL   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PEAK_LEVEL   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_DELAY  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_LENGTH  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FALL_LENGTH  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_LENGTH    = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CYCLE_LENGTH = 3'd6;

  // section codes
  localparam logic [1:0] SEC_BASE = 2'd0;
  localparam logic [1:0] SEC_RISE = 2'd1;
  localparam logic [1:0] SEC_PEAK = 2'd2;
  localparam logic [1:0] SEC_FALL = 2'd3;

endpackage

### sv/trapezoid_pulse_source_core.sv
// Request to result: entry, modulo, segment, section, product, quotient, output stages.
// Throughput: one request per cycle unless a result stalls; the period modulo runs
// as TIME_WIDTH restoring subtract stages and the ramp quotient as LEVEL_WIDTH stages,
// one bit per stage. A stalled result holds the whole pipeline; bubbles do not.
// Reset (rst, synchronous): pipeline empties, config registers 0 except cycle_length = 1.
// Depends on tps_pkg.
module trapezoid_pulse_source_core #(
  parameter int TIME_WIDTH  = tps_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = tps_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // time requests
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [TIME_WIDTH-1:0]                 now_ticks,
  // level results
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic signed [LEVEL_WIDTH-1:0]         level,
  output logic [1:0]                            section,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tps_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [(TIME_WIDTH > LEVEL_WIDTH ? TIME_WIDTH : LEVEL_WIDTH)-1:0] cfg_data
);
  import tps_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int LW = LEVEL_WIDTH;
  localparam int PW = TW + LW;

  typedef struct packed {
    logic          after;
    logic [TW-1:0] rem;
  } mod_t;

  typedef struct packed {
    logic          after;
    logic          lt_rise;
    logic [TW-1:0] p;
    logic [TW-1:0] p1;
  } seg_t;

  typedef struct packed {
    logic [1:0]    sec;
    logic [TW-1:0] off;
    logic [TW-1:0] len;
    logic [LW-1:0] from;
    logic          neg;
  } ramp_t;

  typedef struct packed {
    logic [1:0]    sec;
    logic [TW-1:0] len;
    logic [LW-1:0] from;
    logic          neg;
    logic [PW-1:0] rem;
    logic [LW-1:0] quo;
  } div_t;

  // configuration registers
  logic signed [LW-1:0] base_level;
  logic signed [LW-1:0] peak_level;
  logic [TW-1:0] start_delay;
  logic [TW-1:0] rise_length;
  logic [TW-1:0] fall_length;
  logic [TW-1:0] on_length;
  logic [TW-1:0] cycle_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level   <= '0;
      peak_level   <= '0;
      start_delay  <= '0;
      rise_length  <= '0;
      fall_length  <= '0;
      on_length    <= '0;
      cycle_length <= TW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_LEVEL:   base_level   <= cfg_data[LW-1:0];
        REG_PEAK_LEVEL:   peak_level   <= cfg_data[LW-1:0];
        REG_START_DELAY:  start_delay  <= cfg_data[TW-1:0];
        REG_RISE_LENGTH:  rise_length  <= cfg_data[TW-1:0];
        REG_FALL_LENGTH:  fall_length  <= cfg_data[TW-1:0];
        REG_ON_LENGTH:    on_length    <= cfg_data[TW-1:0];
        REG_CYCLE_LENGTH: cycle_length <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // ramp magnitude and direction, from static registers only
  logic signed [LW:0] diff;
  logic [LW-1:0]      mag;
  logic               neg_rise;
  logic               neg_fall;

  assign diff     = {peak_level[LW-1], peak_level} - {base_level[LW-1], base_level};
  assign neg_rise = diff[LW];
  assign neg_fall = !diff[LW] && (diff != '0);
  assign mag      = diff[LW] ? LW'(-diff) : diff[LW-1:0];

  // global advance: everything moves unless a finished result is held
  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // entry stage: delay test and offset
  logic mod_vld [0:TW];
  mod_t mod_q   [0:TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_vld[0] <= 1'b0;
    end else if (en) begin
      mod_vld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mod_q[0].after <= now_ticks > start_delay;
      mod_q[0].rem   <= now_ticks - start_delay;
    end
  end

  // period modulo, one restoring step per stage; zero period subtracts nothing
  for (genvar k = 0; k < TW; k++) begin : g_mod
    localparam int S = TW - 1 - k;
    logic [2*TW-1:0] dv;
    logic [2*TW-1:0] rw;
    assign dv = {{TW{1'b0}}, cycle_length} << S;
    assign rw = {{TW{1'b0}}, mod_q[k].rem};

    always_ff @(posedge clk) begin
      if (rst) begin
        mod_vld[k+1] <= 1'b0;
      end else if (en) begin
        mod_vld[k+1] <= mod_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mod_q[k+1].after <= mod_q[k].after;
        mod_q[k+1].rem   <= (rw >= dv) ? TW'(rw - dv) : mod_q[k].rem;
      end
    end
  end

  // first segment test
  logic seg_vld;
  seg_t seg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_vld <= 1'b0;
    end else if (en) begin
      seg_vld <= mod_vld[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_q.after   <= mod_q[TW].after;
      seg_q.lt_rise <= mod_q[TW].rem < rise_length;
      seg_q.p       <= mod_q[TW].rem;
      seg_q.p1      <= mod_q[TW].rem - rise_length;
    end
  end

  // section decision and ramp operands
  logic          ramp_vld;
  ramp_t         ramp_q;
  ramp_t         ramp_next;
  logic [TW-1:0] p2;

  assign p2 = seg_q.p1 - on_length;

  always_comb begin
    ramp_next.sec  = SEC_BASE;
    ramp_next.off  = '0;
    ramp_next.len  = TW'(1);
    ramp_next.from = base_level;
    ramp_next.neg  = 1'b0;
    if (seg_q.after) begin
      if (seg_q.lt_rise) begin
        ramp_next.sec = SEC_RISE;
        ramp_next.off = seg_q.p;
        ramp_next.len = rise_length;
        ramp_next.neg = neg_rise;
      end else if (seg_q.p1 < on_length) begin
        ramp_next.sec  = SEC_PEAK;
        ramp_next.from = peak_level;
      end else if (p2 < fall_length) begin
        ramp_next.sec  = SEC_FALL;
        ramp_next.off  = p2;
        ramp_next.len  = fall_length;
        ramp_next.from = peak_level;
        ramp_next.neg  = neg_fall;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_vld <= 1'b0;
    end else if (en) begin
      ramp_vld <= seg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ramp_q <= ramp_next;
    end
  end

  // product magnitude * offset; flat sections give zero over one
  logic div_vld [0:LW];
  div_t div_q   [0:LW];
  logic is_ramp;

  assign is_ramp = (ramp_q.sec == SEC_RISE) || (ramp_q.sec == SEC_FALL);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (en) begin
      div_vld[0] <= ramp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0].sec  <= ramp_q.sec;
      div_q[0].len  <= ramp_q.len;
      div_q[0].from <= ramp_q.from;
      div_q[0].neg  <= ramp_q.neg;
      div_q[0].rem  <= is_ramp ? ({{TW{1'b0}}, mag} * {{LW{1'b0}}, ramp_q.off}) : '0;
      div_q[0].quo  <= '0;
    end
  end

  // ramp quotient, one bit per stage; quotient does not exceed the magnitude
  for (genvar j = 0; j < LW; j++) begin : g_div
    localparam int S = LW - 1 - j;
    logic [PW-1:0] dv;
    logic          qb;
    assign dv = {{LW{1'b0}}, div_q[j].len} << S;
    assign qb = div_q[j].rem >= dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[j+1] <= 1'b0;
      end else if (en) begin
        div_vld[j+1] <= div_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[j+1].sec  <= div_q[j].sec;
        div_q[j+1].len  <= div_q[j].len;
        div_q[j+1].from <= div_q[j].from;
        div_q[j+1].neg  <= div_q[j].neg;
        div_q[j+1].rem  <= qb ? div_q[j].rem - dv : div_q[j].rem;
        div_q[j+1].quo  <= {div_q[j].quo[LW-2:0], qb};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= div_vld[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level   <= div_q[LW].neg ? div_q[LW].from - div_q[LW].quo
                               : div_q[LW].from + div_q[LW].quo;
      section <= div_q[LW].sec;
    end
  end

`ifndef SYNTHESIS
  // period remainder is reduced below a nonzero period
  assert property (@(posedge clk) disable iff (rst)
    mod_vld[TW] && (cycle_length != '0) |-> mod_q[TW].rem < cycle_length)
    else $error("period remainder not reduced");

  // ramp division leaves a remainder below the ramp length
  assert property (@(posedge clk) disable iff (rst)
    div_vld[LW] |-> div_q[LW].rem < div_q[LW].len)
    else $error("ramp remainder out of range");

  // flat sections give the plain register levels
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (section == SEC_PEAK) |-> level == peak_level)
    else $error("peak section level mismatch");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (section == SEC_BASE) |-> level == base_level)
    else $error("base section level mismatch");
`endif

endmodule
